FILE: rtl/mcst_pkg.sv
// Package: shared types, constants and command codes for the soft timer bank.
package mcst_pkg;

  localparam int NumSlots  = 16;
  localparam int TimeWidth = 32;
  localparam int SlotW     = 4;
  localparam int AmountW   = 32;
  localparam int CntW      = $clog2(TimeWidth + 1);

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_ONCE   = 3'd1,
    MODE_PERIOD = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_CREATE = 3'd4,
    MODE_DELETE = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOALLOC = 2'd1,
    ST_NOFREE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DIV,
    S_EMIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [SlotW-1:0]   slot_id;
    logic [AmountW-1:0] amount_us;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] result_slot;
    logic             fired;
    logic             last;
  } out_t;

  // One slot's state as it travels along the ring of cells.
  typedef struct packed {
    logic                 alloc;
    logic                 armed;
    logic                 periodic;
    logic [TimeWidth-1:0] period;
    logic [TimeWidth-1:0] accum;
  } slot_t;

endpackage

FILE: rtl/multi_channel_soft_timer_bank_core.sv
// Top level: command decoder, ring of slot cells and shared remainder unit.
// Non-tick commands: one result after the ring has rotated once, one item at a time.
// Tick: the ring rotates once through NumSlots cells, one slot per cycle while no slot
// fires; it pauses for the remainder unit on each fired slot with a non-zero period and
// to report each fired slot, and output back-pressure can stall it further.
// Reset (asynchronous, active low) frees and disarms every slot.
module multi_channel_soft_timer_bank_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcst_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcst_pkg::out_t  out_data_o
);

  localparam int N = mcst_pkg::NumSlots;
  localparam int W = mcst_pkg::TimeWidth;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  mcst_pkg::slot_t  ring [N];
  mcst_pkg::slot_t  feed;
  logic             shift;
  mcst_pkg::state_e state_q, state_d;
  mcst_pkg::in_t    cmd_q, cmd_d;
  logic [IW:0]      pos_q, pos_d;
  logic [4:0]       nres_q, nres_d;
  logic             hit_q, hit_d;
  mcst_pkg::out_t   res_q, res_d;
  logic             res_v_q, res_v_d;
  mcst_pkg::slot_t  hold_q, hold_d;
  logic             div_start, div_done;
  logic [W-1:0]     div_rem;
  logic [W:0]       sum;
  logic [W-1:0]     acc_new;
  logic             fire;

  // Ring of cells: the head cell feeds back into the tail
  for (genvar g = 0; g < N; g++) begin : g_cell
    mcst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .prev_i ((g == N - 1) ? feed : ring[(g + 1) % N]),
      .slot_o (ring[g])
    );
  end

  // The divisor is taken straight from the head cell in the start cycle; the dividend is its updated accumulator
  mcst_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_new),
    .den_i  (ring[0].period),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Head cell update for the current command
  always_comb begin
    sum     = {1'b0, ring[0].accum} + {1'b0, cmd_q.amount_us[W-1:0]};
    acc_new = sum[W] ? '1 : sum[W-1:0];
    fire    = ring[0].alloc && ring[0].armed && (acc_new >= ring[0].period);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcst_pkg::S_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    nres_q <= nres_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
    hold_q <= hold_d;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    nres_d    = nres_q;
    hit_d     = hit_q;
    res_d     = res_q;
    res_v_d   = res_v_q;
    hold_d    = hold_q;
    shift     = 1'b0;
    feed      = ring[0];
    div_start = 1'b0;
    in_ready_o = (state_q == mcst_pkg::S_IDLE) && !res_v_q;
    if (out_valid_o && out_ready_i) res_v_d = 1'b0;
    unique case (state_q)
      mcst_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_d   = in_data_i;
          pos_d   = '0;
          nres_d  = '0;
          hit_d   = 1'b0;
          res_d   = '0;
          state_d = mcst_pkg::S_SHIFT;
        end
      end
      mcst_pkg::S_SHIFT: begin
        if (pos_q == (IW + 1)'(N)) begin
          state_d = mcst_pkg::S_DONE;
        end else begin
          shift = 1'b1;
          pos_d = pos_q + 1'b1;
          case (cmd_q.mode)
            mcst_pkg::MODE_TICK: begin
              if (ring[0].alloc) feed.accum = acc_new;
              if (fire) begin
                feed.accum = '0;
                if (!ring[0].periodic) feed.armed = 1'b0;
                if (ring[0].period != '0) begin
                  shift     = 1'b0;
                  pos_d     = pos_q;
                  hold_d    = ring[0];
                  hold_d.accum = acc_new;
                  div_start = 1'b1;
                  state_d   = mcst_pkg::S_DIV;
                end else if (nres_q != 5'd16) begin
                  shift   = 1'b0;
                  pos_d   = pos_q;
                  hold_d  = feed;
                  state_d = mcst_pkg::S_EMIT;
                end
              end
            end
            mcst_pkg::MODE_CREATE: begin
              if (!ring[0].alloc && !hit_q) begin
                feed  = '0;
                feed.alloc = 1'b1;
                hit_d = 1'b1;
                res_d.result_slot = pos_q[mcst_pkg::SlotW-1:0];
              end
            end
            default: begin
              if ((IW + 1)'(cmd_q.slot_id) == pos_q && ring[0].alloc) begin
                hit_d = 1'b1;
                case (cmd_q.mode) inside
                  mcst_pkg::MODE_ONCE, mcst_pkg::MODE_PERIOD: begin
                    feed.period   = cmd_q.amount_us[W-1:0];
                    feed.periodic = (cmd_q.mode == mcst_pkg::MODE_PERIOD);
                    feed.accum    = '0;
                    feed.armed    = 1'b1;
                  end
                  mcst_pkg::MODE_STOP: feed.armed = 1'b0;
                  mcst_pkg::MODE_DELETE: feed = '0;
                  default: feed = ring[0];
                endcase
              end
            end
          endcase
        end
      end
      mcst_pkg::S_DIV: begin
        if (div_done) begin
          hold_d.accum = div_rem;
          if (!hold_q.periodic) hold_d.armed = 1'b0;
          if (nres_q != 5'd16) begin
            state_d = mcst_pkg::S_EMIT;
          end else begin
            feed.accum = div_rem;
            feed.armed = hold_q.periodic ? hold_q.armed : 1'b0;
            shift   = 1'b1;
            pos_d   = pos_q + 1'b1;
            state_d = mcst_pkg::S_SHIFT;
          end
        end
      end
      mcst_pkg::S_EMIT: begin
        // Fired slot reported; last is set when no later slot fires
        if (!res_v_q || out_ready_i) begin
          res_v_d = 1'b1;
          res_d   = '0;
          res_d.result_slot = pos_q[mcst_pkg::SlotW-1:0];
          res_d.fired = 1'b1;
          nres_d  = nres_q + 1'b1;
          feed    = hold_q;
          shift   = 1'b1;
          pos_d   = pos_q + 1'b1;
          state_d = mcst_pkg::S_SHIFT;
        end
      end
      mcst_pkg::S_DONE: begin
        if (!res_v_q || out_ready_i) begin
          res_v_d = 1'b1;
          res_d.last = 1'b1;
          if (cmd_q.mode == mcst_pkg::MODE_TICK) begin
            if (nres_q != '0) res_v_d = 1'b0;
            res_d.fired = 1'b0;
            res_d.result_slot = '0;
            res_d.status = mcst_pkg::ST_OK;
          end else if (cmd_q.mode == mcst_pkg::MODE_CREATE) begin
            res_d.status = hit_q ? mcst_pkg::ST_OK : mcst_pkg::ST_NOFREE;
          end else if (cmd_q.mode == mcst_pkg::MODE_ONCE || cmd_q.mode == mcst_pkg::MODE_PERIOD
                    || cmd_q.mode == mcst_pkg::MODE_STOP || cmd_q.mode == mcst_pkg::MODE_DELETE) begin
            res_d.result_slot = cmd_q.slot_id;
            res_d.status = hit_q ? mcst_pkg::ST_OK : mcst_pkg::ST_NOALLOC;
          end
          state_d = mcst_pkg::S_IDLE;
        end
      end
      default: state_d = mcst_pkg::S_IDLE;
    endcase
  end

  // Last flag on a fired report is decided late: hold it until the tick ends
  mcst_pkg::out_t shown;

  always_comb begin
    shown = res_q;
    if (res_q.fired && cmd_q.mode == mcst_pkg::MODE_TICK) begin
      shown.last = (state_q == mcst_pkg::S_DONE) || (state_q == mcst_pkg::S_IDLE);
    end
  end

  // A fired beat is shown only once it is known whether another follows
  assign out_valid_o = res_v_q && (!res_q.fired || (state_q == mcst_pkg::S_DONE)
                       || (state_q == mcst_pkg::S_IDLE) || (state_q == mcst_pkg::S_EMIT));
  assign out_data_o  = shown;

endmodule

FILE: rtl/mcst_cell.sv
// Cell: holds one timer slot and passes it to the next cell when shifting.
module mcst_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mcst_pkg::slot_t prev_i,
  output mcst_pkg::slot_t slot_o
);

  mcst_pkg::slot_t slot_q;

  // The whole slot resets to zero; period and accumulator are also cleared by a create
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= prev_i;
    end
  end

  assign slot_o = slot_q;

endmodule

FILE: rtl/mcst_divider.sv
// Restoring remainder unit: one quotient bit per cycle.
module mcst_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mcst_pkg::TimeWidth-1:0] num_i,
  input  logic [mcst_pkg::TimeWidth-1:0] den_i,
  output logic                           done_o,
  output logic [mcst_pkg::TimeWidth-1:0] rem_o
);

  localparam int W = mcst_pkg::TimeWidth;

  logic [W-1:0]                num_q, num_d;
  logic [W-1:0]                rem_q, rem_d;
  logic [W-1:0]                den_q, den_d;
  logic [mcst_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic [W:0]                  trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[W-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = mcst_pkg::CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[W-1:0];
      end
      num_d = {num_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == mcst_pkg::CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == mcst_pkg::CntW'(1));
  assign rem_o  = rem_d;

endmodule

FILE: rtl/mcst_checker.sv
// Checker: port-level properties of the timer bank, bound to the top level.
module mcst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mcst_pkg::out_t out_data_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // No new command while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with result pending");

  // Status never carries an undefined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

  // A fired report always says ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.status == mcst_pkg::ST_OK)
    else $error("fired result with error status");

endmodule

bind multi_channel_soft_timer_bank_core mcst_checker u_mcst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
